### rtl/sdrs_pkg.sv
// Shared types and constants for the SCAN disk request scheduler.
package sdrs_pkg;

    localparam int DefQueueDepth = 32;
    localparam int TrackW = 16;
    localparam int TagW = 16;
    localparam int StatusW = 2;

    typedef enum logic {
        CMD_PUT = 1'b0,
        CMD_GET = 1'b1
    } cmd_t;

    typedef enum logic [StatusW-1:0] {
        ST_PUT_OK   = 2'd0,
        ST_PUT_FULL = 2'd1,
        ST_DISPATCH = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // One command as it sits in the queue between front and back.
    typedef struct packed {
        cmd_t              command;
        logic [TagW-1:0]   tag;
        logic [TrackW-1:0] track;
        logic [TrackW-1:0] head;
    } cmd_item_t;

endpackage

### rtl/sdrs_cmd_fifo.sv
// Short command queue between the intake stage and the scheduling engine.
module sdrs_cmd_fifo
    import sdrs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  cmd_item_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output cmd_item_t rd_data
);

    cmd_item_t  slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = slot_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Storage slots need no reset.
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (do_wr) begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_rd) begin
                rptr_reg <= ~rptr_reg;
            end
            if (do_wr && !do_rd) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (do_rd && !do_wr) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/sdrs_front.sv
// Intake stage: registers each incoming transaction and classifies its command.
module sdrs_front
    import sdrs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic [TagW-1:0]   s_req_tag,
    input  logic [TrackW-1:0] s_req_track,
    input  logic [TrackW-1:0] s_head_track,
    output logic              q_valid,
    input  logic              q_ready,
    output cmd_item_t         q_data
);

    logic      full_reg;
    cmd_item_t item_reg;

    assign s_ready = !full_reg || q_ready;
    assign q_valid = full_reg;
    assign q_data  = item_reg;

    // Only the fields relevant to the command are kept; the rest are zeroed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                full_reg <= 1'b1;
            end else if (q_ready) begin
                full_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            item_reg.command <= cmd_t'(s_command);
            if (cmd_t'(s_command) == CMD_PUT) begin
                item_reg.tag   <= s_req_tag;
                item_reg.track <= s_req_track;
                item_reg.head  <= '0;
            end else begin
                item_reg.tag   <= '0;
                item_reg.track <= '0;
                item_reg.head  <= s_head_track;
            end
        end
    end

endmodule

### rtl/sdrs_engine.sv
// Scheduling engine: sorted request memory, insert and dispatch sequencer.
module sdrs_engine
    import sdrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DefQueueDepth
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  cmd_item_t         q_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [StatusW-1:0] m_status,
    output logic [TagW-1:0]   m_out_tag,
    output logic [TrackW-1:0] m_out_track
);

    localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_PSCAN, S_PSHIFT, S_GSCAN, S_GSHIFT, S_DONE
    } state_t;

    // Entry memory, one port written and one read per cycle.
    logic [TrackW-1:0] trk_mem [QUEUE_DEPTH];
    logic [TagW-1:0]   tag_mem [QUEUE_DEPTH];
    logic [TrackW-1:0] rd_trk_reg;
    logic [TagW-1:0]   rd_tag_reg;

    state_t            state_reg;
    cmd_item_t         cur_reg;
    logic [CntW-1:0]   count_reg;
    logic              up_reg;
    logic [CntW-1:0]   idx_reg;       // read address issued
    logic              rd_ok_reg;     // read data valid for index idx_reg-1
    logic [CntW-1:0]   pos_reg;
    logic              found_reg;
    logic              hit_reg, below_ok_reg, above_ok_reg;
    logic [IdxW-1:0]   hit_i_reg, below_i_reg, above_i_reg;
    logic [TrackW-1:0] below_t_reg, above_t_reg;
    logic [StatusW-1:0] status_reg;
    logic [TagW-1:0]   otag_reg;
    logic [TrackW-1:0] otrk_reg;
    logic              mv_reg;
    // Memory shift: copy carried from each entry to the next, one entry at a time.
    logic [TrackW-1:0] carry_trk_reg;
    logic [TagW-1:0]   carry_tag_reg;

    logic              we;
    logic [IdxW-1:0]   waddr;
    logic [TrackW-1:0] wtrk;
    logic [TagW-1:0]   wtag;
    logic [IdxW-1:0]   raddr;
    logic [CntW-1:0]   didx;

    assign q_ready     = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid     = mv_reg;
    assign m_status    = status_reg;
    assign m_out_tag   = otag_reg;
    assign m_out_track = otrk_reg;
    assign didx        = idx_reg - CntW'(1);

    // Memory read and write.
    always_ff @(posedge aclk) begin
        if (we) begin
            trk_mem[waddr] <= wtrk;
            tag_mem[waddr] <= wtag;
        end
        rd_trk_reg <= trk_mem[raddr];
        rd_tag_reg <= tag_mem[raddr];
    end

    // Address and write selection.
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wtrk  = carry_trk_reg;
        wtag  = carry_tag_reg;
        raddr = idx_reg[IdxW-1:0];
        case (state_reg)
            S_PSHIFT: begin
                // Write carry at pos, then read-modify ripple toward the tail.
                if (rd_ok_reg) begin
                    we    = 1'b1;
                    waddr = didx[IdxW-1:0];
                end
            end
            S_GSHIFT: begin
                // The chosen entry itself is only read; each later one moves down by one.
                if (rd_ok_reg && found_reg) begin
                    we    = 1'b1;
                    waddr = IdxW'(didx - CntW'(1));
                    wtrk  = rd_trk_reg;
                    wtag  = rd_tag_reg;
                end
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            up_reg    <= 1'b1;
            mv_reg    <= 1'b0;
            idx_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            if (mv_reg && m_ready) begin
                mv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_ready) begin
                        cur_reg      <= q_data;
                        idx_reg      <= '0;
                        rd_ok_reg    <= 1'b0;
                        found_reg    <= 1'b0;
                        pos_reg      <= count_reg;
                        hit_reg      <= 1'b0;
                        below_ok_reg <= 1'b0;
                        above_ok_reg <= 1'b0;
                        otag_reg     <= '0;
                        otrk_reg     <= '0;
                        if (q_data.command == CMD_PUT) begin
                            if (count_reg == DepthC) begin
                                status_reg <= ST_PUT_FULL;
                                state_reg  <= S_DONE;
                            end else begin
                                status_reg <= ST_PUT_OK;
                                state_reg  <= S_PSCAN;
                            end
                        end else begin
                            if (count_reg == '0) begin
                                status_reg <= ST_EMPTY;
                                state_reg  <= S_DONE;
                            end else begin
                                status_reg <= ST_DISPATCH;
                                state_reg  <= S_GSCAN;
                            end
                        end
                    end
                end
                S_PSCAN: begin
                    // Find the first entry with a track above the new one.
                    if (rd_ok_reg && !found_reg && cur_reg.track < rd_trk_reg) begin
                        found_reg <= 1'b1;
                        pos_reg   <= didx;
                    end
                    if (idx_reg < count_reg) begin
                        idx_reg   <= idx_reg + CntW'(1);
                        rd_ok_reg <= 1'b1;
                    end else begin
                        // Scan done: start shifting from the insert point.
                        if (rd_ok_reg && !found_reg && cur_reg.track < rd_trk_reg) begin
                            idx_reg <= didx;
                        end else begin
                            idx_reg <= pos_reg;
                        end
                        rd_ok_reg     <= 1'b0;
                        carry_trk_reg <= cur_reg.track;
                        carry_tag_reg <= cur_reg.tag;
                        state_reg     <= S_PSHIFT;
                    end
                end
                S_PSHIFT: begin
                    // Read entry idx, next cycle write carry there, carry the old.
                    if (rd_ok_reg) begin
                        carry_trk_reg <= rd_trk_reg;
                        carry_tag_reg <= rd_tag_reg;
                        if (didx == count_reg) begin
                            count_reg <= count_reg + CntW'(1);
                            state_reg <= S_DONE;
                        end
                        rd_ok_reg <= 1'b0;
                    end else begin
                        idx_reg   <= idx_reg + CntW'(1);
                        rd_ok_reg <= 1'b1;
                    end
                end
                S_GSCAN: begin
                    if (rd_ok_reg && !hit_reg) begin
                        if (rd_trk_reg == cur_reg.head) begin
                            hit_reg   <= 1'b1;
                            hit_i_reg <= didx[IdxW-1:0];
                        end else if (rd_trk_reg < cur_reg.head) begin
                            // Sorted: later equal tracks must not displace.
                            if (!below_ok_reg || rd_trk_reg > below_t_reg) begin
                                below_ok_reg <= 1'b1;
                                below_i_reg  <= didx[IdxW-1:0];
                                below_t_reg  <= rd_trk_reg;
                            end
                        end else begin
                            if (!above_ok_reg || rd_trk_reg < above_t_reg) begin
                                above_ok_reg <= 1'b1;
                                above_i_reg  <= didx[IdxW-1:0];
                                above_t_reg  <= rd_trk_reg;
                            end
                        end
                    end
                    if (idx_reg < count_reg) begin
                        idx_reg   <= idx_reg + CntW'(1);
                        rd_ok_reg <= 1'b1;
                    end else begin
                        rd_ok_reg <= 1'b0;
                        state_reg <= S_GSHIFT;
                        // Index of the chosen entry; one extra read fetches it.
                        if (rd_ok_reg && !hit_reg && rd_trk_reg == cur_reg.head) begin
                            idx_reg <= didx;
                        end else if (hit_reg) begin
                            idx_reg <= CntW'(hit_i_reg);
                        end else if (up_reg) begin
                            if (above_ok_reg || (rd_ok_reg && rd_trk_reg > cur_reg.head
                                    && !above_ok_reg)) begin
                                idx_reg <= (above_ok_reg) ? CntW'(above_i_reg) : didx;
                            end else begin
                                up_reg  <= 1'b0;
                                idx_reg <= (rd_ok_reg && rd_trk_reg < cur_reg.head &&
                                    (!below_ok_reg || rd_trk_reg > below_t_reg)) ?
                                    didx : CntW'(below_i_reg);
                            end
                        end else begin
                            if (below_ok_reg || (rd_ok_reg && rd_trk_reg < cur_reg.head)) begin
                                idx_reg <= (rd_ok_reg && rd_trk_reg < cur_reg.head &&
                                    (!below_ok_reg || rd_trk_reg > below_t_reg)) ?
                                    didx : CntW'(below_i_reg);
                            end else begin
                                up_reg  <= 1'b1;
                                idx_reg <= (above_ok_reg) ? CntW'(above_i_reg) : didx;
                            end
                        end
                    end
                end
                S_GSHIFT: begin
                    // First read gives the chosen entry; then ripple later ones down.
                    if (!rd_ok_reg) begin
                        idx_reg   <= idx_reg + CntW'(1);
                        rd_ok_reg <= 1'b1;
                        found_reg <= 1'b0;
                    end else begin
                        if (!found_reg) begin
                            otag_reg  <= rd_tag_reg;
                            otrk_reg  <= rd_trk_reg;
                            found_reg <= 1'b1;
                        end
                        if (idx_reg < count_reg) begin
                            idx_reg <= idx_reg + CntW'(1);
                        end else begin
                            rd_ok_reg <= 1'b0;
                            count_reg <= count_reg - CntW'(1);
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!mv_reg) begin
                        mv_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/scan_disk_request_scheduler.sv
// Sequence: a put scans the queued entries, then shifts each entry from the insert point
// toward the tail with a read and then a write; a get scans the queued entries, then reads
// the chosen entry and moves each later one down. The engine takes the next command only
// once the last result has been taken; its scan and shift run on one read and one write port.
// A two-entry command queue lets the intake take commands while the engine works.
// Reset (aresetn low, synchronous) empties the queue and sets the upward sweep.
module scan_disk_request_scheduler
    import sdrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DefQueueDepth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [TagW-1:0]    s_req_tag,
    input  logic [TrackW-1:0]  s_req_track,
    input  logic [TrackW-1:0]  s_head_track,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [StatusW-1:0] m_status,
    output logic [TagW-1:0]    m_out_tag,
    output logic [TrackW-1:0]  m_out_track
);

    logic      f_valid, f_ready, e_valid, e_ready;
    cmd_item_t f_data, e_data;

    sdrs_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command, .s_req_tag,
        .s_req_track, .s_head_track,
        .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    sdrs_cmd_fifo u_fifo (
        .aclk, .aresetn,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(e_valid), .rd_ready(e_ready), .rd_data(e_data)
    );

    sdrs_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
        .aclk, .aresetn,
        .q_valid(e_valid), .q_ready(e_ready), .q_data(e_data),
        .m_valid, .m_ready, .m_status, .m_out_tag, .m_out_track
    );

`ifndef SYNTHESIS
    // A put outcome never carries a request.
    a_put_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_PUT_OK || m_status == ST_PUT_FULL)
        |-> (m_out_tag == '0 && m_out_track == '0))
        else $error("put result carries nonzero payload");
    // An empty report never carries a request.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> (m_out_tag == '0 && m_out_track == '0))
        else $error("empty result carries nonzero payload");
`endif

endmodule
